>>> rtl/bms_pkg.sv
package bms_pkg;

  // default store depth and data word width
  localparam int MAX_ITEMS_DEF = 64;
  localparam int DATA_W        = 64;

  // merge engine status seen by the top level
  typedef struct packed {
    logic done;      // one-cycle pulse, sort finished
    logic res_bank;  // bank that holds the sorted set
  } merge_stat_t;

endpackage

>>> rtl/bms_bank.sv
module bms_bank #(
  parameter int DEPTH = bms_pkg::MAX_ITEMS_DEF,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bms_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr_a,
  input  logic [AW-1:0]             rd_addr_b,
  output logic [bms_pkg::DATA_W-1:0] rd_data_a,
  output logic [bms_pkg::DATA_W-1:0] rd_data_b
);

  logic [bms_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic [bms_pkg::DATA_W-1:0] rd_a_r;
  logic [bms_pkg::DATA_W-1:0] rd_b_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

>>> rtl/bms_merge.sv
module bms_merge #(
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [CW-1:0]              n,
  output logic [AW-1:0]              rd_addr_a,
  output logic [AW-1:0]              rd_addr_b,
  input  logic [bms_pkg::DATA_W-1:0] b0_rd_a,
  input  logic [bms_pkg::DATA_W-1:0] b0_rd_b,
  input  logic [bms_pkg::DATA_W-1:0] b1_rd_a,
  input  logic [bms_pkg::DATA_W-1:0] b1_rd_b,
  output logic                       wr_en0,
  output logic                       wr_en1,
  output logic [AW-1:0]              wr_addr,
  output logic [bms_pkg::DATA_W-1:0] wr_data,
  output bms_pkg::merge_stat_t       stat
);

  // run start plus doubled width stays below three times the set size
  localparam int SW = CW + 2;

  typedef enum logic [1:0] {M_IDLE, M_INIT, M_RD, M_CMP} mstate_t;

  mstate_t       state_r;
  logic          done_r;
  logic          src_r;
  logic [SW-1:0] w_r;
  logic [SW-1:0] s_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] p_r;
  logic [CW-1:0] q_r;
  logic [CW-1:0] k_r;
  logic [CW-1:0] mid_r;
  logic [CW-1:0] hi_r;

  logic [bms_pkg::DATA_W-1:0] head_l;
  logic [bms_pkg::DATA_W-1:0] head_r;
  logic          left_ok;
  logic          right_ok;
  logic          take_right;
  logic [SW-1:0] n_ext;
  logic [SW-1:0] s_w;
  logic [SW-1:0] s_2w;
  logic [SW-1:0] w_2;
  logic [CW-1:0] mid_c;
  logic [CW-1:0] hi_c;
  logic          run_end;

  // heads of the left and right runs from the source bank
  assign head_l = src_r ? b1_rd_a : b0_rd_a;
  assign head_r = src_r ? b1_rd_b : b0_rd_b;

  assign left_ok  = (p_r < mid_r);
  assign right_ok = (q_r < hi_r);
  // left run wins ties, keeps the sort stable
  assign take_right = right_ok && (!left_ok || ($signed(head_l) > $signed(head_r)));

  assign n_ext = SW'(n_r);
  assign w_2   = w_r << 1;
  assign s_w   = s_r + w_r;
  assign s_2w  = s_r + w_2;
  assign mid_c = (s_w < n_ext) ? s_w[CW-1:0] : n_r;
  assign hi_c  = (s_2w < n_ext) ? s_2w[CW-1:0] : n_r;
  assign run_end = ((k_r + CW'(1)) == hi_r);

  assign rd_addr_a = left_ok  ? p_r[AW-1:0] : '0;
  assign rd_addr_b = right_ok ? q_r[AW-1:0] : '0;

  assign wr_data = take_right ? head_r : head_l;
  assign wr_addr = k_r[AW-1:0];
  assign wr_en0  = (state_r == M_CMP) && src_r;
  assign wr_en1  = (state_r == M_CMP) && !src_r;

  assign stat.done     = done_r;
  assign stat.res_bank = src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            n_r   <= n;
            w_r   <= SW'(1);
            s_r   <= '0;
            src_r <= 1'b0;
            if (n < CW'(2)) begin
              done_r <= 1'b1;
            end else begin
              state_r <= M_INIT;
            end
          end
        end
        M_INIT: begin
          mid_r   <= mid_c;
          hi_r    <= hi_c;
          p_r     <= s_r[CW-1:0];
          q_r     <= mid_c;
          k_r     <= s_r[CW-1:0];
          state_r <= M_RD;
        end
        M_RD: begin
          state_r <= M_CMP;
        end
        M_CMP: begin
          k_r <= k_r + CW'(1);
          if (take_right) begin
            q_r <= q_r + CW'(1);
          end else begin
            p_r <= p_r + CW'(1);
          end
          if (run_end) begin
            if (s_2w >= n_ext) begin
              // pass finished, swap banks and double the run width
              src_r <= !src_r;
              s_r   <= '0;
              w_r   <= w_2;
              if (w_2 >= n_ext) begin
                done_r  <= 1'b1;
                state_r <= M_IDLE;
              end else begin
                state_r <= M_INIT;
              end
            end else begin
              s_r     <= s_2w;
              state_r <= M_INIT;
            end
          end else begin
            state_r <= M_RD;
          end
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/bottom_up_merge_sorter_core.sv
// channel   | ports                                        | direction
// ----------+----------------------------------------------+----------
// input     | in_valid, in_ready, in_value, in_last_in     | in
// result    | out_valid, out_ready, out_sorted_value,      | out
//           | out_last_out, out_overflow                   |
//
// load: one transaction per cycle into bank 0 until last_in
// sort: ceil(log2 n) passes, each with one setup state per run and a read then
//   compare/write pair of states per value on the single compare unit
// output: each result steps through S_OUT_RD, S_OUT_LD and S_OUT_WAIT, plus any out_ready stall
// stalls: in_ready is low from the last load until the final result is taken
// reset: synchronous, active low; no memory clearing pass is needed
module bottom_up_merge_sorter_core #(
  parameter int MAX_ITEMS = bms_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bms_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bms_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_last_out,
  output logic                              out_overflow
);

  // address width and count width (count must hold MAX_ITEMS itself)
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {S_LOAD, S_SORT, S_OUT_RD, S_OUT_LD, S_OUT_WAIT} state_t;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] idx_r;
  logic          drop_r;
  logic          start_r;
  logic          res_bank_r;
  logic          out_valid_r;
  logic          out_last_r;
  logic [bms_pkg::DATA_W-1:0] out_value_r;

  logic          in_fire;
  logic          store_ok;
  logic          load_we;
  logic [CW-1:0] count_nxt;

  // merge engine side
  logic [AW-1:0] m_rd_addr_a;
  logic [AW-1:0] m_rd_addr_b;
  logic          m_wr_en0;
  logic          m_wr_en1;
  logic [AW-1:0] m_wr_addr;
  logic [bms_pkg::DATA_W-1:0] m_wr_data;
  bms_pkg::merge_stat_t m_stat;

  // bank ports
  logic [AW-1:0] rd_addr_a;
  logic          b0_we;
  logic [AW-1:0] b0_wr_addr;
  logic [bms_pkg::DATA_W-1:0] b0_wr_data;
  logic [bms_pkg::DATA_W-1:0] b0_rd_a;
  logic [bms_pkg::DATA_W-1:0] b0_rd_b;
  logic [bms_pkg::DATA_W-1:0] b1_rd_a;
  logic [bms_pkg::DATA_W-1:0] b1_rd_b;

  assign in_ready = (state_r == S_LOAD);
  assign in_fire  = in_valid && in_ready;

  // a full store drops the value but still counts as a transaction
  assign store_ok  = (count_r < CW'(MAX_ITEMS));
  assign load_we   = in_fire && store_ok;
  assign count_nxt = store_ok ? (count_r + CW'(1)) : count_r;

  // bank 0 is loaded from the input, otherwise written by the merge engine
  assign b0_we      = load_we || m_wr_en0;
  assign b0_wr_addr = load_we ? count_r[AW-1:0] : m_wr_addr;
  assign b0_wr_data = load_we ? in_value : m_wr_data;

  // port a serves the output phase once sorting is done
  assign rd_addr_a = (state_r == S_SORT) ? m_rd_addr_a : idx_r[AW-1:0];

  bms_bank #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_bank0 (
    .clk       (clk),
    .wr_en     (b0_we),
    .wr_addr   (b0_wr_addr),
    .wr_data   (b0_wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (m_rd_addr_b),
    .rd_data_a (b0_rd_a),
    .rd_data_b (b0_rd_b)
  );

  bms_bank #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_bank1 (
    .clk       (clk),
    .wr_en     (m_wr_en1),
    .wr_addr   (m_wr_addr),
    .wr_data   (m_wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (m_rd_addr_b),
    .rd_data_a (b1_rd_a),
    .rd_data_b (b1_rd_b)
  );

  // ping-pong merge passes between the two banks
  bms_merge #(
    .AW        (AW),
    .CW        (CW)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .n         (n_r),
    .rd_addr_a (m_rd_addr_a),
    .rd_addr_b (m_rd_addr_b),
    .b0_rd_a   (b0_rd_a),
    .b0_rd_b   (b0_rd_b),
    .b1_rd_a   (b1_rd_a),
    .b1_rd_b   (b1_rd_b),
    .wr_en0    (m_wr_en0),
    .wr_en1    (m_wr_en1),
    .wr_addr   (m_wr_addr),
    .wr_data   (m_wr_data),
    .stat      (m_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      drop_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            count_r <= count_nxt;
            if (!store_ok) begin
              drop_r <= 1'b1;
            end
            if (in_last_in) begin
              // set closed, kick off the sort
              n_r     <= count_nxt;
              start_r <= 1'b1;
              state_r <= S_SORT;
            end
          end
        end
        S_SORT: begin
          if (m_stat.done) begin
            res_bank_r <= m_stat.res_bank;
            idx_r      <= '0;
            state_r    <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          // read address is idx_r, data lands next cycle
          state_r <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_value_r <= res_bank_r ? b1_rd_a : b0_rd_a;
          out_last_r  <= ((idx_r + CW'(1)) == n_r);
          out_valid_r <= 1'b1;
          state_r     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              // set done, start a fresh one
              count_r <= '0;
              drop_r  <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              idx_r   <= idx_r + CW'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = drop_r;

endmodule
